// File: rtl/pmi_pkg.sv
package pmi_pkg;

  typedef logic signed [47:0] q_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COORD,
    S_CONST,
    S_TERM,
    S_LATCH,
    S_PWAIT,
    S_CSTART,
    S_CWAIT,
    S_POP,
    S_ESTART,
    S_EWAIT,
    S_STORE,
    S_FLAGS
  } state_t;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_STEP = 2'd2;

  localparam logic [1:0] CFG_DIM = 2'd0;
  localparam logic [1:0] CFG_ORD = 2'd1;
  localparam logic [1:0] CFG_EUL = 2'd2;
  localparam logic [1:0] CFG_EPS = 2'd3;

  localparam q_t          POINT_RESET   = 48'sd838861;
  localparam logic [24:0] EPS_RESET     = 25'd1677722;
  localparam logic [49:0] DIVERGE_LIMIT = 50'd16777216000000;
  localparam logic [50:0] SETTLE_LIMIT  = 51'd17;
  localparam q_t          Q_MAX         = 48'sh7FFFFFFFFFFF;
  localparam q_t          Q_MIN         = 48'sh800000000000;

  typedef struct packed {
    logic start;
    q_t   a;
    q_t   b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic sat;
    q_t   res;
  } mul_rsp_t;

  typedef struct packed {
    logic sat;
    q_t   val;
  } sum_t;

  function automatic logic [47:0] q_mag(q_t a);
    return a[47] ? 48'(-a) : 48'(a);
  endfunction

  function automatic sum_t q_add(q_t a, q_t b);
    logic signed [48:0] s;
    sum_t r;
    s = {a[47], a} + {b[47], b};
    r.sat = (s[48] != s[47]);
    r.val = r.sat ? (s[48] ? Q_MIN : Q_MAX) : s[47:0];
    return r;
  endfunction

endpackage

// File: rtl/pmi_in_if.sv
interface pmi_in_if import pmi_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [8:0] coef_index;
  q_t         coef_value;
  q_t         seed_x;
  q_t         seed_y;
  q_t         seed_z;
  q_t         seed_w;

  modport source (output valid, mode, coef_index, coef_value, seed_x, seed_y, seed_z, seed_w,
                  input ready);
  modport sink (input valid, mode, coef_index, coef_value, seed_x, seed_y, seed_z, seed_w,
                output ready);
endinterface

// File: rtl/pmi_out_if.sv
interface pmi_out_if import pmi_pkg::*; ();
  logic valid;
  logic ready;
  q_t   x_out;
  q_t   y_out;
  q_t   z_out;
  q_t   w_out;
  logic diverged;
  logic settled;

  modport source (output valid, x_out, y_out, z_out, w_out, diverged, settled, input ready);
  modport sink (input valid, x_out, y_out, z_out, w_out, diverged, settled, output ready);
endinterface

// File: rtl/polynomial_map_iterator_core.sv
// Polynomial map iterator, Q24.24 signed 48-bit, up to four coordinates, order up to five.
// in_ch carries requests: mode load writes coef_value at coef_index into the coefficient
// RAM, mode set loads seed_x..seed_w as the point, mode step runs one map iteration.
// Only a step request produces a result on out_ch: the new point, with unused coordinates
// zero, plus diverged and settled flags. cfg_we/cfg_index/cfg_data write dimension, order,
// euler_mode and step_size; write them only while no step is in flight.
// Load and set requests complete on acceptance. A step walks all coefficient terms
// through one shared multiplier that forms a 48x48 product as four 24x24 partial
// products; each term does a coefficient read, a prefix multiply (above first order),
// a coefficient multiply and an accumulate, plus stack pops, per-coordinate setup and
// store, and the Euler update when enabled. A full 4-dimension, order-5 map has 504
// terms. in_ch.ready is high only while no step is running.
// Reset restores the register defaults and the point to 0.05 in all coordinates; the
// coefficient RAM keeps its contents and must be loaded before use.
// The result sits in an output register; while out_ch is stalled, load and set requests
// are still taken, and a following step holds its result until the register frees up.
module polynomial_map_iterator_core import pmi_pkg::*; #(
  parameter int COEFF_DEPTH = 512,
  parameter int MAX_DIM     = 4,
  parameter int MAX_ORDER   = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  pmi_in_if.sink       in_ch,
  pmi_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [24:0]  cfg_data
);

  localparam int RA_W   = $clog2(COEFF_DEPTH);
  localparam int ACNT_W = (RA_W + 1 > 9) ? RA_W + 1 : 9;
  localparam int DW     = $clog2(MAX_ORDER);

  state_t state_r, state_nxt;

  logic [2:0]  dim_r, ord_r;
  logic        eul_r;
  logic [24:0] eps_r;

  q_t          cur_r [4];
  q_t          nxt_r [4];
  q_t          pre_r [MAX_ORDER];
  logic [2:0]  stk_r [MAX_ORDER];
  q_t          acc_r, p_r, coef_r;
  logic [2:0]  d_r, i_r;
  logic [1:0]  coord_r;
  logic [ACNT_W-1:0] addr_r;
  logic        oor_r;
  logic        sat_r;
  logic [2:0]  edim_r, eord_r;

  logic        out_valid_r;
  q_t          out_x_r, out_y_r, out_z_r, out_w_r;
  logic        out_div_r, out_set_r;

  logic        in_acc;
  logic        ram_we, ram_re;
  logic [RA_W-1:0] ram_addr;
  q_t          ram_rdata;
  q_t          coef_rd;
  mul_req_t    mreq;
  mul_rsp_t    mrsp;
  logic        out_load;
  logic [1:0]  cur_idx;
  q_t          cur_sel;
  logic [DW-1:0] lvl_w, lvl_r;
  sum_t        acc_sum, eul_sum;
  logic [2:0]  edim_c, eord_c;
  logic [49:0] abs_sum;
  logic [50:0] chg_sum;
  logic signed [48:0] dif [4];
  logic        load_ok;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign load_ok = {{(ACNT_W-9){1'b0}}, in_ch.coef_index} < ACNT_W'(COEFF_DEPTH);
  assign coef_rd = oor_r ? '0 : ram_rdata;
  assign lvl_w   = DW'(d_r - 3'd1);
  assign lvl_r   = DW'(d_r - 3'd2);
  assign cur_idx = (state_r == S_EWAIT) ? coord_r : i_r[1:0];
  assign cur_sel = cur_r[cur_idx];
  assign acc_sum = q_add(acc_r, mrsp.res);
  assign eul_sum = q_add(cur_sel, mrsp.res);

  assign edim_c = (dim_r == 3'd0) ? 3'd1 : ((dim_r > 3'(MAX_DIM)) ? 3'(MAX_DIM) : dim_r);
  assign eord_c = (ord_r < 3'd2) ? 3'd2 : ((ord_r > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : ord_r);

  always_comb begin
    abs_sum = '0;
    chg_sum = '0;
    for (int k = 0; k < 4; k++) begin
      dif[k]  = {nxt_r[k][47], nxt_r[k]} - {cur_r[k][47], cur_r[k]};
      abs_sum = abs_sum + {2'b0, q_mag(nxt_r[k])};
      chg_sum = chg_sum + {2'b0, (dif[k][48] ? 49'(-dif[k]) : 49'(dif[k]))};
    end
  end

  pmi_ram #(.WIDTH(48), .DEPTH(COEFF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_ch.coef_value),
    .rdata (ram_rdata)
  );

  pmi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc && in_ch.mode == MODE_STEP) state_nxt = S_COORD;
      S_COORD:  state_nxt = S_CONST;
      S_CONST:  state_nxt = S_TERM;
      S_TERM:   state_nxt = S_LATCH;
      S_LATCH:  state_nxt = (d_r == 3'd1) ? S_CSTART : S_PWAIT;
      S_PWAIT:  if (mrsp.done) state_nxt = S_CSTART;
      S_CSTART: state_nxt = S_CWAIT;
      S_CWAIT:  if (mrsp.done) state_nxt = (d_r < eord_r) ? S_TERM : S_POP;
      S_POP: begin
        if (i_r != edim_r) begin
          state_nxt = S_TERM;
        end else if (d_r == 3'd1) begin
          state_nxt = eul_r ? S_ESTART : S_STORE;
        end
      end
      S_ESTART: state_nxt = S_EWAIT;
      S_EWAIT:  if (mrsp.done) state_nxt = S_STORE;
      S_STORE:  state_nxt = ({1'b0, coord_r} == edim_r - 3'd1) ? S_FLAGS : S_COORD;
      S_FLAGS:  if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = addr_r[RA_W-1:0];
    mreq.start  = 1'b0;
    mreq.a      = pre_r[lvl_r];
    mreq.b      = cur_sel;
    out_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        ram_addr    = RA_W'(in_ch.coef_index);
        ram_we      = in_acc && in_ch.mode == MODE_LOAD && load_ok;
      end
      S_COORD, S_TERM: ram_re = 1'b1;
      S_LATCH:  mreq.start = (d_r != 3'd1);
      S_CSTART: begin
        mreq.start = 1'b1;
        mreq.a     = coef_r;
        mreq.b     = p_r;
      end
      S_ESTART: begin
        mreq.start = 1'b1;
        mreq.a     = {23'b0, eps_r};
        mreq.b     = acc_r;
      end
      S_FLAGS:  out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= 3'd2;
      ord_r       <= 3'd2;
      eul_r       <= 1'b0;
      eps_r       <= EPS_RESET;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        cur_r[k] <= POINT_RESET;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIM: dim_r <= cfg_data[2:0];
          CFG_ORD: ord_r <= cfg_data[2:0];
          CFG_EUL: eul_r <= cfg_data[0];
          CFG_EPS: eps_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && in_ch.mode == MODE_SET) begin
        cur_r[0] <= in_ch.seed_x;
        cur_r[1] <= in_ch.seed_y;
        cur_r[2] <= in_ch.seed_z;
        cur_r[3] <= in_ch.seed_w;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        for (int k = 0; k < 4; k++) begin
          cur_r[k] <= nxt_r[k];
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.mode == MODE_STEP) begin
          edim_r  <= edim_c;
          eord_r  <= eord_c;
          addr_r  <= '0;
          coord_r <= 2'd0;
          sat_r   <= 1'b0;
          for (int k = 0; k < 4; k++) begin
            nxt_r[k] <= '0;
          end
        end
      end
      S_COORD: begin
        oor_r  <= addr_r >= ACNT_W'(COEFF_DEPTH);
        addr_r <= addr_r + 1'b1;
      end
      S_CONST: begin
        acc_r <= coef_rd;
        d_r   <= 3'd1;
        i_r   <= 3'd0;
      end
      S_TERM: begin
        oor_r  <= addr_r >= ACNT_W'(COEFF_DEPTH);
        addr_r <= addr_r + 1'b1;
        if (d_r == 3'd1) begin
          p_r          <= cur_sel;
          pre_r[lvl_w] <= cur_sel;
        end
      end
      S_LATCH: coef_r <= coef_rd;
      S_PWAIT: begin
        if (mrsp.done) begin
          p_r          <= mrsp.res;
          pre_r[lvl_w] <= mrsp.res;
          if (mrsp.sat) begin
            sat_r <= 1'b1;
          end
        end
      end
      S_CWAIT: begin
        if (mrsp.done) begin
          acc_r <= acc_sum.val;
          if (acc_sum.sat || mrsp.sat) begin
            sat_r <= 1'b1;
          end
          if (d_r < eord_r) begin
            stk_r[lvl_w] <= i_r;
            d_r          <= d_r + 3'd1;
          end else begin
            i_r <= i_r + 3'd1;
          end
        end
      end
      S_POP: begin
        if (i_r == edim_r && d_r != 3'd1) begin
          d_r <= d_r - 3'd1;
          i_r <= stk_r[lvl_r] + 3'd1;
        end
      end
      S_EWAIT: begin
        if (mrsp.done) begin
          acc_r <= eul_sum.val;
          if (eul_sum.sat || mrsp.sat) begin
            sat_r <= 1'b1;
          end
        end
      end
      S_STORE: begin
        nxt_r[coord_r] <= acc_r;
        coord_r        <= coord_r + 2'd1;
      end
      S_FLAGS: begin
        if (out_load) begin
          out_x_r   <= nxt_r[0];
          out_y_r   <= nxt_r[1];
          out_z_r   <= nxt_r[2];
          out_w_r   <= nxt_r[3];
          out_div_r <= (abs_sum > DIVERGE_LIMIT) || sat_r;
          out_set_r <= chg_sum < SETTLE_LIMIT;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.x_out    = out_x_r;
  assign out_ch.y_out    = out_y_r;
  assign out_ch.z_out    = out_z_r;
  assign out_ch.w_out    = out_w_r;
  assign out_ch.diverged = out_div_r;
  assign out_ch.settled  = out_set_r;

endmodule

// File: rtl/pmi_ram.sv
module pmi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/pmi_mul.sv
module pmi_mul import pmi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic        run_r;
  logic [2:0]  cnt_r;
  logic [47:0] ua_r, ub_r;
  logic        neg_r;
  logic [47:0] prod_r;
  logic [47:0] hi_r;
  logic [49:0] mid_r;
  logic [48:0] lo_r;
  logic        done_r;
  logic        sat_r;
  q_t          res_r;

  logic [23:0] pa, pb;
  logic [50:0] q;
  logic [50:0] limit;
  logic        sat;
  logic [47:0] qs;

  always_comb begin
    case (cnt_r)
      3'd0:    begin pa = ua_r[47:24]; pb = ub_r[47:24]; end
      3'd1:    begin pa = ua_r[47:24]; pb = ub_r[23:0];  end
      3'd2:    begin pa = ua_r[23:0];  pb = ub_r[47:24]; end
      default: begin pa = ua_r[23:0];  pb = ub_r[23:0];  end
    endcase
  end

  always_comb begin
    q     = {3'b0, hi_r[23:0], 24'b0} + {1'b0, mid_r} + {26'b0, lo_r[48:24]};
    limit = neg_r ? 51'h800000000000 : 51'h7FFFFFFFFFFF;
    sat   = (hi_r >= 48'h800000) || (q > limit);
    qs    = sat ? limit[47:0] : q[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= 3'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ua_r  <= q_mag(req.a);
      ub_r  <= q_mag(req.b);
      neg_r <= req.a[47] ^ req.b[47];
    end
    if (run_r) begin
      prod_r <= pa * pb;
      case (cnt_r)
        3'd1:    hi_r  <= prod_r;
        3'd2:    mid_r <= {2'b0, prod_r};
        3'd3:    mid_r <= mid_r + {2'b0, prod_r};
        3'd4:    lo_r  <= {1'b0, prod_r} + 49'h800000;
        3'd5: begin
          sat_r <= sat;
          res_r <= neg_r ? q_t'(-qs) : q_t'(qs);
        end
        default: ;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.res  = res_r;

endmodule

// File: test/tb_polynomial_map_iterator_core.sv
`timescale 1ns / 1ps

module tb_polynomial_map_iterator_core;
  import pmi_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0] mode;
    logic [8:0] idx;
    q_t         val;
    q_t         seed[4];
  } req_t;

  typedef struct {
    q_t   crd[4];
    logic div;
    logic stl;
  } point_t;

  class map_predictor;
    logic [2:0]  dim_reg;
    logic [2:0]  ord_reg;
    logic        eul_reg;
    logic [24:0] eps_reg;
    q_t          pt[4];
    q_t          coef_mem[512];
    bit          written[512];
    point_t      expected_points[$];
    int          errors;
    q_t          walk_acc;
    q_t          walk_crd[4];
    int          walk_dim;
    int          walk_ord;
    int          walk_addr;
    bit          walk_sat;

    function new();
      dim_reg = 3'd2;
      ord_reg = 3'd2;
      eul_reg = 1'b0;
      eps_reg = EPS_RESET;
      foreach (pt[i]) pt[i] = POINT_RESET;
      errors = 0;
    endfunction

    function void set_cfg(logic [1:0] idx, logic [24:0] data);
      case (idx)
        CFG_DIM: dim_reg = data[2:0];
        CFG_ORD: ord_reg = data[2:0];
        CFG_EUL: eul_reg = data[0];
        CFG_EPS: eps_reg = data;
      endcase
    endfunction

    function int eff_dim();
      return dim_reg == 0 ? 1 : (dim_reg > 4 ? 4 : int'(dim_reg));
    endfunction

    function int eff_ord();
      return ord_reg < 2 ? 2 : (ord_reg > 5 ? 5 : int'(ord_reg));
    endfunction

    function int terms_needed();
      int c;
      int d;
      int o;
      d = eff_dim();
      o = eff_ord();
      c = 1;
      for (int k = 1; k <= o; k++) c = c * (d + k) / k;
      return c * d;
    endfunction

    function q_t qmul(q_t a, q_t b);
      logic [47:0] ua;
      logic [47:0] ub;
      logic [95:0] q;
      logic [47:0] lim;
      bit          neg;
      ua = a[47] ? 48'(-a) : 48'(a);
      ub = b[47] ? 48'(-b) : 48'(b);
      neg = a[47] ^ b[47];
      q = (({48'd0, ua} * {48'd0, ub}) + 96'd8388608) >> 24;
      lim = neg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
      if (q > {48'd0, lim} || (ua[47:24] * ub[47:24]) >= 48'h800000) begin
        walk_sat = 1;
        q = {48'd0, lim};
      end
      return neg ? q_t'(-q[47:0]) : q_t'(q[47:0]);
    endfunction

    function q_t qadd(q_t a, q_t b);
      logic signed [48:0] s;
      s = {a[47], a} + {b[47], b};
      if (s[48] != s[47]) begin
        walk_sat = 1;
        return s[48] ? Q_MIN : Q_MAX;
      end
      return s[47:0];
    endfunction

    function q_t fetch_coef();
      q_t c;
      c = walk_addr < 512 ? coef_mem[walk_addr] : '0;
      walk_addr++;
      return c;
    endfunction

    function void walk_terms(int depth, int first, q_t prefix);
      q_t p;
      q_t c;
      for (int i = first; i < walk_dim; i++) begin
        p = depth == 1 ? walk_crd[i] : qmul(prefix, walk_crd[i]);
        c = fetch_coef();
        walk_acc = qadd(walk_acc, qmul(c, p));
        if (depth < walk_ord) walk_terms(depth + 1, i, p);
      end
    endfunction

    function void note_request(req_t r);
      point_t      e;
      logic [63:0] abs_sum;
      logic [63:0] chg_sum;
      longint      d;
      case (r.mode)
        MODE_LOAD: begin
          coef_mem[r.idx] = r.val;
          written[r.idx] = 1;
        end
        MODE_SET: begin
          foreach (pt[i]) pt[i] = r.seed[i];
        end
        MODE_STEP: begin
          walk_dim = eff_dim();
          walk_ord = eff_ord();
          walk_crd = pt;
          walk_addr = 0;
          walk_sat = 0;
          for (int i = 0; i < 4; i++) begin
            if (i >= walk_dim) begin
              e.crd[i] = '0;
            end else begin
              walk_acc = fetch_coef();
              walk_terms(1, 0, '0);
              if (eul_reg) walk_acc = qadd(walk_crd[i], qmul(q_t'({23'd0, eps_reg}), walk_acc));
              e.crd[i] = walk_acc;
            end
          end
          abs_sum = 0;
          chg_sum = 0;
          for (int i = 0; i < 4; i++) begin
            d = longint'(e.crd[i]);
            abs_sum += d < 0 ? 64'(-d) : 64'(d);
            d = longint'(e.crd[i]) - longint'(walk_crd[i]);
            chg_sum += d < 0 ? 64'(-d) : 64'(d);
          end
          pt = e.crd;
          e.div = (abs_sum > (64'd1000000 << 24)) || walk_sat;
          e.stl = chg_sum < 64'd17;
          expected_points.insert(expected_points.size(), e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(point_t a);
      point_t e;
      string  nm[4];
      nm = '{"x_out", "y_out", "z_out", "w_out"};
      if (expected_points.size() == 0) begin
        $error("unexpected result x_out %0d", a.crd[0]);
        errors++;
        return;
      end
      e = expected_points.pop_front();
      for (int i = 0; i < 4; i++)
        if (a.crd[i] !== e.crd[i]) begin
          $error("%s expected %0d actual %0d", nm[i], e.crd[i], a.crd[i]);
          errors++;
        end
      if (a.div !== e.div) begin
        $error("diverged expected %0d actual %0d", e.div, a.div);
        errors++;
      end
      if (a.stl !== e.stl) begin
        $error("settled expected %0d actual %0d", e.stl, a.stl);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [24:0] cfg_data;
  int          idle_pct;
  int          stall_pct;
  int          cyc;

  pmi_in_if  in_if();
  pmi_out_if out_if();
  map_predictor sb = new();

  polynomial_map_iterator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    point_t a;
    if (rst_n && out_if.valid && out_if.ready) begin
      a.crd = '{out_if.x_out, out_if.y_out, out_if.z_out, out_if.w_out};
      a.div = out_if.diverged;
      a.stl = out_if.settled;
      sb.check_result(a);
    end
  end

  function automatic q_t rnd_val(int full_pct);
    q_t v;
    if ($urandom_range(99) < full_pct) v = q_t'({$urandom, $urandom});
    else v = q_t'($urandom_range(8388607)) - 48'sd4194304;
    return v;
  endfunction

  task automatic send(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= r.mode;
    in_if.coef_index <= r.idx;
    in_if.coef_value <= r.val;
    in_if.seed_x     <= r.seed[0];
    in_if.seed_y     <= r.seed[1];
    in_if.seed_z     <= r.seed[2];
    in_if.seed_w     <= r.seed[3];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  function automatic req_t make_req(logic [1:0] mode, int full_pct);
    req_t r;
    r.mode = mode;
    r.idx = 9'($urandom);
    r.val = rnd_val(full_pct);
    foreach (r.seed[i]) r.seed[i] = rnd_val(full_pct);
    return r;
  endfunction

  task automatic load_coef(input int idx, input q_t val);
    req_t r;
    r = make_req(MODE_LOAD, 0);
    r.idx = 9'(idx);
    r.val = val;
    send(r);
  endtask

  task automatic step_map();
    int n;
    n = sb.terms_needed();
    for (int a = 0; a < n; a++)
      if (!sb.written[a]) load_coef(a, rnd_val(5));
    send(make_req(MODE_STEP, 0));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_points.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input int d, input int o, input int e, input int eps);
    logic [24:0] v[4];
    drain();
    v = '{25'(d), 25'(o), 25'(e), 25'(eps)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= v[i];
      sb.set_cfg(2'(i), v[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    req_t r;
    int   cd[8];
    int   co[8];
    int   ce[8];
    int   cs[8];
    int   cnt;
    int   sel;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 0;
    in_if.mode = '0;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.seed_x = '0;
    in_if.seed_y = '0;
    in_if.seed_z = '0;
    in_if.seed_w = '0;
    out_if.ready = 0;
    idle_pct = 0;
    stall_pct = 0;
    cyc = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(make_req(MODE_NONE, 50));
    load_coef(511, Q_MAX);
    load_coef(510, Q_MIN);
    step_map();
    step_map();

    write_cfg(1, 2, 0, EPS_RESET);
    for (int a = 0; a < 4; a++) load_coef(a, '0);
    r = make_req(MODE_SET, 0);
    r.seed = '{Q_MAX, Q_MIN, '0, -48'sd1};
    send(r);
    step_map();
    step_map();
    load_coef(0, Q_MAX);
    load_coef(1, Q_MIN);
    send(r);
    step_map();

    cd = '{0, 2, 3, 7, 1, 4, 2, 5};
    co = '{0, 3, 2, 7, 5, 2, 6, 1};
    ce = '{0, 1, 1, 1, 0, 0, 1, 1};
    cs = '{1677722, 1677722, 0, 33554431, 16777216, 5, 123456, 1};
    for (int p = 0; p < 12; p++) begin
      if (p < 8) write_cfg(cd[p], co[p], ce[p], cs[p]);
      else write_cfg($urandom_range(1, 3), $urandom_range(2, 3), $urandom_range(1),
                     $urandom_range(16777216));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      cnt = p == 3 ? 12 : 40;
      for (int k = 0; k < cnt; k++) begin
        if (p == 1 && k == cnt / 2) drain();
        sel = $urandom_range(99);
        if (sel < 12) send(make_req(MODE_LOAD, 10));
        else if (sel < 24) send(make_req(MODE_SET, 10));
        else if (sel < 28) send(make_req(MODE_NONE, 50));
        else step_map();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.expected_points.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
